>>> hdl/rof_pkg.sv
// ----------------------------------------------------------------------------
// rof_pkg: shared types and constants of the 3x3 rank-order filter
// Pixel and field widths, register indexes, mode codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rof_pkg;

   localparam int PIX_W     = 8;
   localparam int ROW_W     = 10;
   localparam int COL_W     = 10;
   localparam int MODE_W    = 2;
   localparam int SIZE_W    = 11;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int WIN       = 3;
   localparam int WIN_TAPS  = WIN * WIN;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   // rank selection codes; the unused code selects the maximum
   localparam logic [MODE_W-1:0] MODE_MIN    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAX    = 2'd2;

   localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd1024;
   localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd1024;

   typedef logic [WIN_TAPS-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [PIX_W-1:0] value;
      logic             filtered;
      logic             last;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/rof_line_store.sv
// ----------------------------------------------------------------------------
// rof_line_store: two-row line store
// One memory word per column holds the upper and middle row pixels; one
// write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rof_line_store #(
   parameter int DEPTH = rof_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic      [rof_pkg::PIX_W-1:0] rd_top,
   output logic      [rof_pkg::PIX_W-1:0] rd_mid,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [rof_pkg::PIX_W-1:0] wr_top,
   input  wire logic [rof_pkg::PIX_W-1:0] wr_mid
);

   localparam int WORD_W = 2 * rof_pkg::PIX_W;

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= {wr_top, wr_mid};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_top = rd_data_ff[WORD_W-1:rof_pkg::PIX_W];
   assign rd_mid = rd_data_ff[rof_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

>>> hdl/rof_rank.sv
// ----------------------------------------------------------------------------
// rof_rank: rank selection over a 3x3 window
// Minimum and maximum trees plus a 19-exchange median network.
// ----------------------------------------------------------------------------
`default_nettype none

module rof_rank (
   input  wire logic [rof_pkg::MODE_W-1:0] mode,
   input  wire rof_pkg::window_type        window,
   output logic      [rof_pkg::PIX_W-1:0]  value
);

   localparam int PW = rof_pkg::PIX_W;

   logic [PW-1:0] min_val;
   logic [PW-1:0] max_val;
   logic [PW-1:0] med_val;

   // returns {low, high}
   function automatic logic [2*PW-1:0] sort_pair(input logic [PW-1:0] a,
                                                 input logic [PW-1:0] b);
      return (a > b) ? {b, a} : {a, b};
   endfunction

   function automatic logic [PW-1:0] min2(input logic [PW-1:0] a,
                                          input logic [PW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PW-1:0] max2(input logic [PW-1:0] a,
                                          input logic [PW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   assign min_val = min2(min2(min2(min2(window[0], window[1]), min2(window[2], window[3])),
                              min2(min2(window[4], window[5]), min2(window[6], window[7]))),
                         window[8]);

   assign max_val = max2(max2(max2(max2(window[0], window[1]), max2(window[2], window[3])),
                              max2(max2(window[4], window[5]), max2(window[6], window[7]))),
                         window[8]);

   always_comb begin
      logic [rof_pkg::WIN_TAPS-1:0][PW-1:0] p;
      p = window;
      {p[1], p[2]} = sort_pair(p[1], p[2]);
      {p[4], p[5]} = sort_pair(p[4], p[5]);
      {p[7], p[8]} = sort_pair(p[7], p[8]);
      {p[0], p[1]} = sort_pair(p[0], p[1]);
      {p[3], p[4]} = sort_pair(p[3], p[4]);
      {p[6], p[7]} = sort_pair(p[6], p[7]);
      {p[1], p[2]} = sort_pair(p[1], p[2]);
      {p[4], p[5]} = sort_pair(p[4], p[5]);
      {p[7], p[8]} = sort_pair(p[7], p[8]);
      {p[0], p[3]} = sort_pair(p[0], p[3]);
      {p[5], p[8]} = sort_pair(p[5], p[8]);
      {p[4], p[7]} = sort_pair(p[4], p[7]);
      {p[3], p[6]} = sort_pair(p[3], p[6]);
      {p[1], p[4]} = sort_pair(p[1], p[4]);
      {p[2], p[5]} = sort_pair(p[2], p[5]);
      {p[4], p[7]} = sort_pair(p[4], p[7]);
      {p[2], p[4]} = sort_pair(p[2], p[4]);
      {p[4], p[6]} = sort_pair(p[4], p[6]);
      {p[2], p[4]} = sort_pair(p[2], p[4]);
      med_val = p[4];
   end

   always_comb begin
      case (mode)
         rof_pkg::MODE_MIN:    value = min_val;
         rof_pkg::MODE_MEDIAN: value = med_val;
         default:              value = max_val;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/rank_order_filter_3x3.sv
// The first result of an item passes the window stage and output buffer registers; a
// second result (right or bottom border) follows once the first is taken. Throughput:
// 1 item per cycle unless the output buffer holds the window stage; the line store has
// one read and one write port. Two-result items hold back the next item with a result.
// Reset (synchronous): clears counters, window and output buffer and restores
// register defaults; the line store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// rank_order_filter_3x3: streaming 3x3 min / median / max filter
// Raster-order 8-bit pixels in, filtered interior and passthrough border
// pixels out, with row and column tags.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_order_filter_3x3 #(
   parameter int MAX_WIDTH  = rof_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = rof_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [rof_pkg::ADDR_W-1:0] paddr,
   input  wire logic [rof_pkg::DATA_W-1:0] pwdata,
   output logic      [rof_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [rof_pkg::PIX_W-1:0]  req_pixel,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [rof_pkg::ROW_W-1:0]  rsp_out_row,
   output logic      [rof_pkg::COL_W-1:0]  rsp_out_column,
   output logic      [rof_pkg::PIX_W-1:0]  rsp_out_value,
   output logic                            rsp_is_filtered,
   output logic                            rsp_last_of_run
);

   localparam int PW  = rof_pkg::PIX_W;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WSZ = (CW + 1 > rof_pkg::SIZE_W) ? CW + 1 : rof_pkg::SIZE_W;
   localparam int HSZ = (RW + 1 > rof_pkg::SIZE_W) ? RW + 1 : rof_pkg::SIZE_W;

   // configuration registers
   logic [rof_pkg::MODE_W-1:0] mode_ff;
   logic [rof_pkg::SIZE_W-1:0] width_ff;
   logic [rof_pkg::SIZE_W-1:0] height_ff;
   logic                       cfg_wr;
   logic [1:0]                 cfg_idx;

   // position counters
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [WSZ-1:0] width_eff, width_ext;
   logic [HSZ-1:0] height_eff, height_ext;
   logic [CW-1:0]  cur_col;
   logic [HSZ-1:0] cur_row_x;
   logic [WSZ-1:0] nxt_col_x;
   logic [HSZ-1:0] nxt_row_x;
   logic           cur_filt;
   logic           cur_pass;
   logic           req_take;

   // window stage
   logic                     s1_valid_ff, s1_valid_in;
   logic [PW-1:0]            s1_pix_ff;
   logic [CW-1:0]            s1_col_ff;
   logic [RW-1:0]            s1_row_ff;
   logic                     s1_filt_ff;
   logic                     s1_pass_ff;
   logic                     s1_adv;
   logic [5:0][PW-1:0]       win_ff;
   logic [PW-1:0]            ls_top;
   logic [PW-1:0]            ls_mid;
   rof_pkg::window_type      window;
   logic [PW-1:0]            rank_val;
   logic [RW-1:0]            filt_row;
   logic [CW-1:0]            filt_col;

   // output buffer
   rof_pkg::result_type      slot0_ff, slot0_in;
   rof_pkg::result_type      slot1_ff, slot1_in;
   rof_pkg::result_type      filt_res;
   rof_pkg::result_type      pass_res;
   logic [1:0]               out_cnt_ff, out_cnt_in;
   logic                     out_free;
   logic                     rsp_take;

   // ---------------------------------------------------------------- csr
   assign pready  = 1'b1;
   assign cfg_idx = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rof_pkg::MODE_MEDIAN;
         width_ff  <= rof_pkg::RST_WIDTH;
         height_ff <= rof_pkg::RST_HEIGHT;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            rof_pkg::REG_FILTER_MODE:  mode_ff   <= pwdata[rof_pkg::MODE_W-1:0];
            rof_pkg::REG_IMAGE_WIDTH:  width_ff  <= pwdata[rof_pkg::SIZE_W-1:0];
            rof_pkg::REG_IMAGE_HEIGHT: height_ff <= pwdata[rof_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         rof_pkg::REG_FILTER_MODE:  prdata = rof_pkg::DATA_W'(mode_ff);
         rof_pkg::REG_IMAGE_WIDTH:  prdata = rof_pkg::DATA_W'(width_ff);
         rof_pkg::REG_IMAGE_HEIGHT: prdata = rof_pkg::DATA_W'(height_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- counters
   always_comb begin
      width_ext  = WSZ'(width_ff);
      height_ext = HSZ'(height_ff);
      if (width_ext < WSZ'(rof_pkg::WIN)) begin
         width_eff = WSZ'(rof_pkg::WIN);
      end else if (width_ext > WSZ'(MAX_WIDTH)) begin
         width_eff = WSZ'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (height_ext < HSZ'(rof_pkg::WIN)) begin
         height_eff = HSZ'(rof_pkg::WIN);
      end else if (height_ext > HSZ'(MAX_HEIGHT)) begin
         height_eff = HSZ'(MAX_HEIGHT);
      end else begin
         height_eff = height_ext;
      end
   end

   always_comb begin
      // wrap first if the size shrank below the stored position
      cur_col   = col_ff;
      cur_row_x = HSZ'(row_ff);
      if (WSZ'(col_ff) >= width_eff) begin
         cur_col   = '0;
         cur_row_x = HSZ'(row_ff) + HSZ'(1);
      end
      if (cur_row_x >= height_eff) begin
         cur_row_x = '0;
      end

      nxt_col_x = WSZ'(cur_col) + WSZ'(1);
      nxt_row_x = cur_row_x;
      if (nxt_col_x >= width_eff) begin
         nxt_col_x = '0;
         nxt_row_x = cur_row_x + HSZ'(1);
         if (nxt_row_x >= height_eff) begin
            nxt_row_x = '0;
         end
      end
      col_in = nxt_col_x[CW-1:0];
      row_in = nxt_row_x[RW-1:0];

      cur_filt = (cur_row_x >= HSZ'(2)) && (WSZ'(cur_col) >= WSZ'(2));
      cur_pass = (cur_row_x == '0) || (cur_row_x >= height_eff - HSZ'(1)) ||
                 (cur_col == '0) || (WSZ'(cur_col) >= width_eff - WSZ'(1));
   end

   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------- line store
   rof_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_take),
      .rd_addr (cur_col),
      .rd_top  (ls_top),
      .rd_mid  (ls_mid),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_top  (ls_mid),
      .wr_mid  (s1_pix_ff)
   );

   // ------------------------------------------------------ window stage
   assign out_free    = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_ready);
   assign s1_adv      = s1_valid_ff && (!(s1_filt_ff || s1_pass_ff) || out_free);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pix_ff  <= req_pixel;
         s1_col_ff  <= cur_col;
         s1_row_ff  <= cur_row_x[RW-1:0];
         s1_filt_ff <= cur_filt;
         s1_pass_ff <= cur_pass;
      end
   end

   // columns c-2 (entries 0..2) and c-1 (entries 3..5), top to bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= {s1_pix_ff, ls_mid, ls_top, win_ff[5], win_ff[4], win_ff[3]};
      end
   end

   assign window = {s1_pix_ff, win_ff[5], win_ff[2],
                    ls_mid,    win_ff[4], win_ff[1],
                    ls_top,    win_ff[3], win_ff[0]};

   rof_rank u_rank (
      .mode   (mode_ff),
      .window (window),
      .value  (rank_val)
   );

   assign filt_row = s1_row_ff - RW'(1);
   assign filt_col = s1_col_ff - CW'(1);

   always_comb begin
      filt_res.row      = rof_pkg::ROW_W'(filt_row);
      filt_res.column   = rof_pkg::COL_W'(filt_col);
      filt_res.value    = rank_val;
      filt_res.filtered = 1'b1;
      filt_res.last     = !s1_pass_ff;
      pass_res.row      = rof_pkg::ROW_W'(s1_row_ff);
      pass_res.column   = rof_pkg::COL_W'(s1_col_ff);
      pass_res.value    = s1_pix_ff;
      pass_res.filtered = 1'b0;
      pass_res.last     = 1'b1;
   end

   // ------------------------------------------------------ output buffer
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      out_cnt_in = out_cnt_ff;
      if (s1_adv && (s1_filt_ff || s1_pass_ff)) begin
         // filtered centre is earlier in raster order, so it goes first
         slot0_in   = s1_filt_ff ? filt_res : pass_res;
         slot1_in   = pass_res;
         out_cnt_in = (s1_filt_ff && s1_pass_ff) ? 2'd2 : 2'd1;
      end else if (rsp_take) begin
         slot0_in   = slot1_ff;
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid       = (out_cnt_ff != 2'd0);
   assign rsp_out_row     = slot0_ff.row;
   assign rsp_out_column  = slot0_ff.column;
   assign rsp_out_value   = slot0_ff.value;
   assign rsp_is_filtered = slot0_ff.filtered;
   assign rsp_last_of_run = slot0_ff.last;

   // ---------------------------------------------------------- checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_not_last_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> out_cnt_ff == 2'd2)
      else $error("non-final item result without a second result queued");

   a_take_to_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item did not reach the window stage");

   a_second_is_pass: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff == 2'd2 |-> slot0_ff.filtered && !slot1_ff.filtered)
      else $error("two queued results are not filtered then passthrough");

endmodule

`default_nettype wire
